### design/rhht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhht_pkg
// Shared types and codes for the Robin Hood hash table.
// ----------------------------------------------------------------------------
package rhht_pkg;
    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_ERASE  = 2'd2;
    // The spare code is handled as a lookup.
    localparam logic [1:0] FUNC_SPARE  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam int MAX_DIST = 127;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] key_hash;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [31:0] value_out;
        logic [1:0]  status;
        logic [10:0] entry_count;
    } t_rsp;
endpackage
`default_nettype wire

### design/robin_hood_hash_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// robin_hood_hash_table_top
// Robin Hood open-addressing table with backward-shift erase, one slot a step.
// ----------------------------------------------------------------------------
// Channel  Direction  Signals
// request  in         i_valid, o_ready, i_req
// response out        o_valid, i_ready, o_rsp
// config   in         i_cfg_we, i_cfg_wdata (load_limit)
//
// Each slot read is issued in a read state (S_FRD, S_DRD, S_IRD, S_ERD) and its
// registered data is used in the matching check state; an insert adds a dry run
// and a write pass, an erase adds a shift pass that reads, checks and moves each entry.
// After reset a clearing pass empties the info memory, one slot a step;
// no request is taken meanwhile. A stalled response holds the block.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_top #(
    parameter int CAPACITY_LOG2 = 10,
    parameter int KEY_WIDTH     = 32,
    parameter int VALUE_WIDTH   = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire rhht_pkg::t_req i_req,
    output logic                o_valid,
    input  wire                 i_ready,
    output rhht_pkg::t_rsp      o_rsp,
    input  wire                 i_cfg_we,
    input  wire [9:0]           i_cfg_wdata
);
    localparam int AW = CAPACITY_LOG2;
    localparam int DEPTH = 1 << AW;
    localparam logic [10:0] CAP11 = (DEPTH > 1024) ? 11'h7FF : 11'(DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FRD, S_FCHK, S_DRD, S_DCHK,
        S_IRD, S_ICHK, S_ERD, S_ECHK, S_EMOV, S_RESP
    } t_state;

    logic [7:0]             r_info [DEPTH];
    logic [KEY_WIDTH-1:0]   r_skey [DEPTH];
    logic [31:0]            r_shash[DEPTH];
    logic [VALUE_WIDTH-1:0] r_sval [DEPTH];

    t_state                 r_state;
    logic [AW-1:0]          r_idx, r_pos;
    logic [7:0]             r_d;
    logic [AW:0]            r_steps;
    logic [1:0]             r_func;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [31:0]            r_hash;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [9:0]             r_limit;
    logic [10:0]            r_count;
    logic                   r_found;
    logic [VALUE_WIDTH-1:0] r_vout;
    logic [1:0]             r_status;
    logic                   r_ovalid;

    // Registered memory read data.
    logic [7:0]             r_rinfo;
    logic [KEY_WIDTH-1:0]   r_rkey;
    logic [31:0]            r_rhash;
    logic [VALUE_WIDTH-1:0] r_rval;

    logic                   we;
    logic [AW-1:0]          waddr;
    logic [7:0]             winfo;
    logic                   wfull;
    logic [KEY_WIDTH-1:0]   wkey;
    logic [31:0]            whash;
    logic [VALUE_WIDTH-1:0] wval;

    logic [6:0] rdist;
    logic       rtaken;
    assign rdist  = r_rinfo[6:0];
    assign rtaken = r_rinfo[7];

    always_ff @(posedge i_clk) begin
        r_rinfo <= r_info[r_idx];
        r_rkey  <= r_skey[r_idx];
        r_rhash <= r_shash[r_idx];
        r_rval  <= r_sval[r_idx];
        if (we) begin
            r_info[waddr] <= winfo;
            if (wfull) begin
                r_skey[waddr]  <= wkey;
                r_shash[waddr] <= whash;
                r_sval[waddr]  <= wval;
            end
        end
    end

    // Write port select.
    always_comb begin
        we = 1'b0; waddr = r_idx; winfo = 8'h00; wfull = 1'b0;
        wkey = r_key; whash = r_hash; wval = r_val;
        unique case (r_state)
            S_CLEAR: we = 1'b1;
            S_ICHK: begin
                if (!rtaken || (r_d[6:0] > rdist)) begin
                    we = 1'b1; wfull = 1'b1; winfo = {1'b1, r_d[6:0]};
                end
            end
            S_ECHK: begin
                waddr = r_pos; we = 1'b1;
                if (rtaken && rdist != 7'd0 && r_steps != (AW+1)'(DEPTH - 1)) begin
                    wfull = 1'b1; winfo = r_rinfo - 8'd1;
                    wkey = r_rkey; whash = r_rhash; wval = r_rval;
                end
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_rsp.found       = r_found;
    assign o_rsp.value_out   = 32'(r_vout);
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_limit  <= 10'd972;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_func  <= i_req.func;
                        r_key   <= KEY_WIDTH'(i_req.key);
                        r_hash  <= i_req.key_hash;
                        r_val   <= VALUE_WIDTH'(i_req.value);
                        r_idx   <= i_req.key_hash[AW-1:0];
                        r_d     <= '0;
                        r_found <= 1'b0;
                        r_vout  <= '0;
                        r_state <= S_FRD;
                    end
                end
                S_FRD: r_state <= S_FCHK;
                S_FCHK: begin
                    if (rtaken && {1'b0, rdist} == r_d && r_rkey == r_key) begin
                        r_found <= 1'b1; r_vout <= r_rval; r_pos <= r_idx;
                        if (r_func == rhht_pkg::FUNC_ERASE) begin
                            r_idx <= r_idx + 1'b1; r_steps <= '0;
                            r_state <= S_ERD;
                        end else begin
                            r_status <= (r_func == rhht_pkg::FUNC_INSERT)
                                ? rhht_pkg::ST_PRESENT : rhht_pkg::ST_OK;
                            r_state <= S_RESP;
                        end
                    end else if (!rtaken || {1'b0, rdist} < r_d
                                 || r_d == 8'(rhht_pkg::MAX_DIST)) begin
                        if (r_func == rhht_pkg::FUNC_INSERT) begin
                            if (r_count >= {1'b0, r_limit} || r_count >= CAP11) begin
                                r_status <= rhht_pkg::ST_FULL;
                                r_state <= S_RESP;
                            end else begin
                                r_idx <= r_hash[AW-1:0]; r_d <= '0; r_steps <= '0;
                                r_state <= S_DRD;
                            end
                        end else begin
                            r_status <= rhht_pkg::ST_MISSING;
                            r_state <= S_RESP;
                        end
                    end else begin
                        r_d <= r_d + 8'd1; r_idx <= r_idx + 1'b1; r_state <= S_FRD;
                    end
                end
                S_DRD: r_state <= S_DCHK;
                S_DCHK: begin
                    if (!rtaken) begin
                        r_idx <= r_hash[AW-1:0]; r_d <= '0; r_steps <= '0;
                        r_state <= S_IRD;
                    end else if (((r_d > {1'b0, rdist}) ? {1'b0, rdist} : r_d)
                                 >= 8'(rhht_pkg::MAX_DIST)
                                 || r_steps == (AW+1)'(DEPTH - 1)) begin
                        r_status <= rhht_pkg::ST_FULL; r_state <= S_RESP;
                    end else begin
                        r_d <= ((r_d > {1'b0, rdist}) ? {1'b0, rdist} : r_d) + 8'd1;
                        r_idx <= r_idx + 1'b1; r_steps <= r_steps + 1'b1;
                        r_state <= S_DRD;
                    end
                end
                S_IRD: r_state <= S_ICHK;
                S_ICHK: begin
                    if (!rtaken) begin
                        r_count <= r_count + 11'd1;
                        r_status <= rhht_pkg::ST_OK; r_state <= S_RESP;
                    end else begin
                        if (r_d[6:0] > rdist) begin
                            r_key <= r_rkey; r_hash <= r_rhash; r_val <= r_rval;
                            r_d <= {1'b0, rdist + 7'd1};
                        end else begin
                            r_d <= {1'b0, r_d[6:0] + 7'd1};
                        end
                        r_idx <= r_idx + 1'b1; r_state <= S_IRD;
                    end
                end
                S_ERD: r_state <= S_ECHK;
                S_ECHK: begin
                    // On the shift bound or an empty or home slot, r_pos is emptied.
                    if (rtaken && rdist != 7'd0 && r_steps != (AW+1)'(DEPTH - 1)) begin
                        r_pos <= r_idx; r_idx <= r_idx + 1'b1;
                        r_steps <= r_steps + 1'b1; r_state <= S_EMOV;
                    end else begin
                        if (r_count != 11'd0) r_count <= r_count - 11'd1;
                        r_status <= rhht_pkg::ST_OK; r_state <= S_RESP;
                    end
                end
                S_EMOV: r_state <= S_ERD;
                S_RESP: begin
                    r_ovalid <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### design/robin_hood_hash_table_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// robin_hood_hash_table_checker
// Port-level checks of the request and response channels.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_ready,
    input wire                 o_valid,
    input wire                 i_ready,
    input wire rhht_pkg::t_rsp o_rsp
);
    // No new request while a response waits.
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while response pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp)) else $error("response dropped");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.entry_count <= 11'd1024) else $error("count overflow");
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.found |-> o_rsp.value_out == 32'd0) else $error("value on miss");
endmodule

bind robin_hood_hash_table_top robin_hood_hash_table_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
);
`default_nettype wire
